/* hw/rtl/teq_pkg.sv */
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

  localparam int KIND_W       = 3;
  localparam int DELAY_W      = 32;
  localparam int HALF_W       = DELAY_W + 1;
  localparam int DEV_W        = 6;
  localparam int RSN_W        = 16;
  localparam int FIELD_TIME_W = 48;
  localparam int LIMIT_W      = 7;
  localparam int MAX_RESULTS  = 32;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS);
  localparam int RUN_CNT_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SERVICE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_SUM   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_EMIT  = 6'b010000,
    S_REPLY = 6'b100000
  } teq_state_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } teq_cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/teq_cell.sv */
// ----------------------------------------------------------------------------
// teq_cell
// One slot of the sorted event chain: keeps, takes the new event, or takes
// a neighbour's event on insert and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_cell #(
  parameter int TIME_BITS = 48
) (
  input  logic                         clk,
  input  teq_pkg::teq_cell_ctrl_t      ctrl,
  input  logic                         occupied,
  input  logic [TIME_BITS-1:0]         ins_time,
  input  logic [teq_pkg::DEV_W-1:0]    ins_device,
  input  logic [teq_pkg::RSN_W-1:0]    ins_reason,
  input  logic                         prev_le,
  input  logic [TIME_BITS-1:0]         prev_time,
  input  logic [teq_pkg::DEV_W-1:0]    prev_device,
  input  logic [teq_pkg::RSN_W-1:0]    prev_reason,
  input  logic [TIME_BITS-1:0]         next_time,
  input  logic [teq_pkg::DEV_W-1:0]    next_device,
  input  logic [teq_pkg::RSN_W-1:0]    next_reason,
  output logic                         le,
  output logic [TIME_BITS-1:0]         cell_time,
  output logic [teq_pkg::DEV_W-1:0]    cell_device,
  output logic [teq_pkg::RSN_W-1:0]    cell_reason
);
  import teq_pkg::*;

  assign le = occupied && (cell_time <= ins_time);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!le) begin
        if (prev_le) begin
          cell_time   <= ins_time;
          cell_device <= ins_device;
          cell_reason <= ins_reason;
        end else begin
          cell_time   <= prev_time;
          cell_device <= prev_device;
          cell_reason <= prev_reason;
        end
      end
    end else if (ctrl.pop) begin
      cell_time   <= next_time;
      cell_device <= next_device;
      cell_reason <= next_reason;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/timed_event_queue_top.sv */
// ----------------------------------------------------------------------------
// timed_event_queue_top
// Time-ordered event store built as a chain of slots kept sorted by time.
// ----------------------------------------------------------------------------
// One item is handled at a time. An insert that finds room goes through
// delay conversion, time sum, parallel sorted shift of the chain, then the
// reply beat, after which the next item can be taken. An insert refused by a
// full store goes straight to the reply beat. Service and flush emit one
// event beat per cycle while the result register is not stalled, each pop
// shifting the whole chain by one slot; with nothing due a single empty beat
// follows. Discard, query and unused kinds go straight to the reply beat.
// A stalled result register holds the sequence back.
// No clearing pass after reset.
`default_nettype none

module timed_event_queue_top #(
  parameter int CAPACITY  = 32,
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [teq_pkg::KIND_W-1:0]          kind,
  input  logic [teq_pkg::FIELD_TIME_W-1:0]    now_time,
  input  logic [teq_pkg::DELAY_W-1:0]         delay_us,
  input  logic [teq_pkg::DEV_W-1:0]           device_id,
  input  logic [teq_pkg::RSN_W-1:0]           reason_code,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                event_valid,
  output logic [teq_pkg::DEV_W-1:0]           out_device,
  output logic [teq_pkg::RSN_W-1:0]           out_reason,
  output logic [teq_pkg::FIELD_TIME_W-1:0]    event_time,
  output logic                                any_found,
  output logic                                queue_full,
  output logic                                limit_exceeded,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [teq_pkg::LIMIT_W-1:0]         cfg_data
);
  import teq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  teq_state_t              state;
  logic [CNT_W-1:0]        count;
  logic [LIMIT_W-1:0]      event_limit;
  logic [KIND_W-1:0]       kind_q;
  logic [TIME_BITS-1:0]    now_q;
  logic [DELAY_W-1:0]      delay_q;
  logic [DEV_W-1:0]        dev_q;
  logic [RSN_W-1:0]        rsn_q;
  logic [HALF_W-1:0]       half;
  logic [TIME_BITS-1:0]    new_time;
  logic                    full_q;
  logic [RES_CNT_W-1:0]    res_n;
  logic [RUN_CNT_W-1:0]    run_cnt;
  logic [TIME_BITS-1:0]    ref_time;

  logic [TIME_BITS-1:0]    cell_time   [CAPACITY];
  logic [DEV_W-1:0]        cell_device [CAPACITY];
  logic [RSN_W-1:0]        cell_reason [CAPACITY];
  logic [CAPACITY-1:0]     cell_le;
  teq_cell_ctrl_t          cell_ctrl;

  logic                    item_accept;
  logic                    out_load;
  logic                    out_write;
  logic                    is_flush;
  logic                    is_query;
  logic                    can_head;
  logic                    head_due;
  logic                    second_due;
  logic [RUN_CNT_W-1:0]    run_next;
  logic                    over;
  logic                    stop_after;
  logic                    store_full;
  logic [DELAY_W+2:0]      times_five;

  assign cfg_ready   = 1'b1;
  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign out_load    = !result_valid || !result_stall;
  assign out_write   = out_load && (state == S_EMIT || state == S_REPLY);

  assign is_flush   = (kind_q == KIND_FLUSH);
  assign is_query   = (kind_q == KIND_QUERY);
  assign store_full = (count >= CNT_W'(CAPACITY));
  assign head_due   = (cell_time[0] <= now_q);
  assign second_due = (cell_time[1] <= now_q);
  assign can_head   = (count != '0) && (is_flush || head_due);
  assign run_next   = (is_flush && cell_time[0] != ref_time) ? RUN_CNT_W'(1)
                                                             : run_cnt + 1'b1;
  assign over       = (LIMIT_W'(run_next) > event_limit);
  assign stop_after = over || (res_n == RES_CNT_W'(MAX_RESULTS - 1)) ||
                      (count == CNT_W'(1)) || (!is_flush && !second_due);
  assign times_five = {3'b000, delay_q} + {1'b0, delay_q, 2'b00};

  assign cell_ctrl.ins = (state == S_SHIFT);
  assign cell_ctrl.pop = (state == S_EMIT) && out_load && can_head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 occ;
    logic                 p_le;
    logic [TIME_BITS-1:0] p_time;
    logic [DEV_W-1:0]     p_dev;
    logic [RSN_W-1:0]     p_rsn;
    logic [TIME_BITS-1:0] n_time;
    logic [DEV_W-1:0]     n_dev;
    logic [RSN_W-1:0]     n_rsn;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign p_le   = 1'b1;
      assign p_time = new_time;
      assign p_dev  = dev_q;
      assign p_rsn  = rsn_q;
    end else begin : g_mid
      assign p_le   = cell_le[i-1];
      assign p_time = cell_time[i-1];
      assign p_dev  = cell_device[i-1];
      assign p_rsn  = cell_reason[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_time = cell_time[i];
      assign n_dev  = cell_device[i];
      assign n_rsn  = cell_reason[i];
    end else begin : g_body
      assign n_time = cell_time[i+1];
      assign n_dev  = cell_device[i+1];
      assign n_rsn  = cell_reason[i+1];
    end

    teq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .occupied    (occ),
      .ins_time    (new_time),
      .ins_device  (dev_q),
      .ins_reason  (rsn_q),
      .prev_le     (p_le),
      .prev_time   (p_time),
      .prev_device (p_dev),
      .prev_reason (p_rsn),
      .next_time   (n_time),
      .next_device (n_dev),
      .next_reason (n_rsn),
      .le          (cell_le[i]),
      .cell_time   (cell_time[i]),
      .cell_device (cell_device[i]),
      .cell_reason (cell_reason[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      event_limit  <= LIMIT_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        event_limit <= cfg_data;
      end
      if (out_write) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_accept) begin
            case (kind)
              KIND_INSERT: state <= store_full ? S_REPLY : S_CONV;
              KIND_SERVICE, KIND_FLUSH: state <= S_EMIT;
              KIND_DISCARD: begin
                count <= '0;
                state <= S_REPLY;
              end
              default: state <= S_REPLY;
            endcase
          end
        end
        S_CONV:  state <= S_SUM;
        S_SUM:   state <= S_SHIFT;
        S_SHIFT: begin
          count <= count + 1'b1;
          state <= S_REPLY;
        end
        S_EMIT: begin
          if (out_load) begin
            if (can_head) begin
              count <= count - 1'b1;
              if (stop_after) begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_REPLY: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      kind_q   <= kind;
      now_q    <= TIME_BITS'(now_time);
      delay_q  <= delay_us;
      dev_q    <= device_id;
      rsn_q    <= reason_code;
      full_q   <= (kind == KIND_INSERT) && store_full;
      res_n    <= '0;
      run_cnt  <= '0;
      ref_time <= TIME_BITS'(now_time);
    end
    if (state == S_CONV) begin
      half <= times_five[DELAY_W+2:2];
    end
    if (state == S_SUM) begin
      new_time <= now_q + TIME_BITS'(half);
    end
    if (cell_ctrl.pop) begin
      res_n    <= res_n + 1'b1;
      run_cnt  <= run_next;
      ref_time <= cell_time[0];
    end
    if (out_write) begin
      if (state == S_EMIT && can_head) begin
        event_valid    <= 1'b1;
        out_device     <= cell_device[0];
        out_reason     <= cell_reason[0];
        event_time     <= FIELD_TIME_W'(cell_time[0]);
        any_found      <= 1'b1;
        queue_full     <= 1'b0;
        limit_exceeded <= over;
        last           <= stop_after;
      end else begin
        event_valid    <= 1'b0;
        out_device     <= '0;
        out_reason     <= '0;
        event_time     <= (state == S_REPLY && is_query && count != '0)
                          ? FIELD_TIME_W'(cell_time[0]) : '0;
        any_found      <= (state == S_REPLY) && is_query && (count != '0);
        queue_full     <= (state == S_REPLY) && full_q;
        limit_exceeded <= 1'b0;
        last           <= 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("event count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |=> (count == $past(count) + 1'b1))
    else $error("insert did not add one event");

  a_limit_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && limit_exceeded) |-> (last && event_valid))
    else $error("limit beat not marked last");

  a_pop_on_event: assert property (@(posedge clk) disable iff (rst)
    cell_ctrl.pop |-> (count != '0 && !cell_ctrl.ins))
    else $error("pop from empty chain");

  for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      (CNT_W'(j + 1) < count) |-> (cell_time[j] <= cell_time[j+1]))
      else $error("event chain out of order");
  end

endmodule

`default_nettype wire
